// ----- hdl/rhd_pkg.sv -----
// Package with the shared constants and the result type of the cartridge header decoder.
package rhd_pkg;

  // Header signature bytes "NES" followed by the end-of-file marker.
  localparam logic [7:0] MagicB0 = 8'h4E;
  localparam logic [7:0] MagicB1 = 8'h45;
  localparam logic [7:0] MagicB2 = 8'h53;
  localparam logic [7:0] MagicB3 = 8'h1A;

  // Byte 7 bits 3:2 carry this code in a version two header.
  localparam logic [1:0] Nes2IdCode = 2'b10;

  // Size nibble code that selects the exponent-multiplier form.
  localparam logic [3:0] ExpFormNibble = 4'hF;

  // RAM sizes.
  localparam logic [21:0] OldWorkRamBytes = 22'd8192;
  localparam logic [21:0] RamBaseBytes    = 22'd64;

  // Largest size class reported in the fabric flags word.
  localparam logic [2:0] MaxSizeClass = 3'd7;

  typedef struct packed {
    logic        header_ok;
    logic        is_version_two;
    logic [11:0] mapper_number;
    logic [3:0]  submapper_number;
    logic [31:0] prg_size_bytes;
    logic [31:0] chr_size_bytes;
    logic [21:0] work_ram_bytes;
    logic [21:0] saved_ram_bytes;
    logic [1:0]  tv_region;
    logic [4:0]  cart_bits;
    logic [63:0] fabric_flags;
  } rhd_result_t;

endpackage

// ----- hdl/rhd_in_if.sv -----
// Input channel interface: one header transaction as two 64-bit words.
interface rhd_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] header_low;
  logic [63:0] header_high;

  modport source (output valid, output header_low, output header_high, input ready);
  modport sink (input valid, input header_low, input header_high, output ready);
endinterface

// ----- hdl/rhd_out_if.sv -----
// Output channel interface: one decoded header transaction.
interface rhd_out_if;
  logic        valid;
  logic        ready;
  logic        header_ok;
  logic        is_version_two;
  logic [11:0] mapper_number;
  logic [3:0]  submapper_number;
  logic [31:0] prg_size_bytes;
  logic [31:0] chr_size_bytes;
  logic [21:0] work_ram_bytes;
  logic [21:0] saved_ram_bytes;
  logic [1:0]  tv_region;
  logic [4:0]  cart_bits;
  logic [63:0] fabric_flags;

  modport source (
    output valid, output header_ok, output is_version_two, output mapper_number,
    output submapper_number, output prg_size_bytes, output chr_size_bytes,
    output work_ram_bytes, output saved_ram_bytes, output tv_region,
    output cart_bits, output fabric_flags, input ready
  );
  modport sink (
    input valid, input header_ok, input is_version_two, input mapper_number,
    input submapper_number, input prg_size_bytes, input chr_size_bytes,
    input work_ram_bytes, input saved_ram_bytes, input tv_region,
    input cart_bits, input fabric_flags, output ready
  );
endinterface

// ----- hdl/rhd_rom_size.sv -----
// ROM size decoder: byte count in both size forms plus the clamped log2 size class.
module rhd_rom_size (
  input  logic [3:0]  msb_nib_i,
  input  logic [7:0]  lsb_i,
  input  logic        v2_i,
  input  logic        prg_sel_i,
  output logic [31:0] size_o,
  output logic [2:0]  class_o
);
  import rhd_pkg::*;

  logic [11:0] base;
  logic [31:0] lin_size;
  logic [4:0]  exp_shift;
  logic [2:0]  odd_mult;
  logic [34:0] exp_wide;
  logic [31:0] exp_size;
  logic        use_exp;
  logic [19:0] units;

  // Multiplier form: the old format has no high nibble.
  assign base     = v2_i ? {msb_nib_i, lsb_i} : {4'h0, lsb_i};
  assign lin_size = prg_sel_i ? {6'h00, base, 14'h0000} : {7'h00, base, 13'h0000};

  // Exponent form: 2^E * (2M+1), saturating at the all-ones value.
  assign exp_shift = lsb_i[6:2];
  assign odd_mult  = {lsb_i[1:0], 1'b1};
  assign exp_wide  = {32'h0, odd_mult} << exp_shift;
  assign exp_size  = (lsb_i[7] || (|exp_wide[34:32])) ? 32'hFFFF_FFFF : exp_wide[31:0];

  assign use_exp = v2_i && (msb_nib_i == ExpFormNibble);
  assign size_o  = use_exp ? exp_size : lin_size;

  // Unit count rounded up; a zero size gives class zero either way.
  always_comb begin
    if (prg_sel_i) begin
      units = {2'b00, size_o[31:14]} + {19'h0, |size_o[13:0]};
    end else begin
      units = {1'b0, size_o[31:13]} + {19'h0, |size_o[12:0]};
    end
  end

  // Smallest class whose power of two covers the unit count.
  always_comb begin
    class_o = MaxSizeClass;
    for (int c = 6; c >= 0; c--) begin
      if (units <= (20'h1 << c)) begin
        class_o = 3'(c);
      end
    end
  end

endmodule

// ----- hdl/rhd_decode.sv -----
// Header field decode: magic check, format detection, mapper, sizes and flag packing.
module rhd_decode (
  input  logic [63:0]         header_low_i,
  input  logic [63:0]         header_high_i,
  output rhd_pkg::rhd_result_t result_o
);
  import rhd_pkg::*;

  logic [7:0]  b4, b5, b6, b7, b8, b9, b10, b12;
  logic        magic_ok;
  logic        v2;
  logic        dirty;
  logic [11:0] mapper;
  logic [3:0]  sub;
  logic [31:0] prg_size, chr_size;
  logic [2:0]  prg_class, chr_class;
  logic        chr_ram;

  assign b4  = header_low_i[39:32];
  assign b5  = header_low_i[47:40];
  assign b6  = header_low_i[55:48];
  assign b7  = header_low_i[63:56];
  assign b8  = header_high_i[7:0];
  assign b9  = header_high_i[15:8];
  assign b10 = header_high_i[23:16];
  assign b12 = header_high_i[39:32];

  assign magic_ok = header_low_i[31:0] == {MagicB3, MagicB2, MagicB1, MagicB0};
  assign v2       = b7[3:2] == Nes2IdCode;

  // Old headers with junk in bytes 9 to 15 keep only the low mapper nibble.
  assign dirty = |header_high_i[63:8];

  always_comb begin
    if (v2) begin
      mapper = {b8[3:0], b7[7:4], b6[7:4]};
    end else if (dirty) begin
      mapper = {8'h00, b6[7:4]};
    end else begin
      mapper = {4'h0, b7[7:4], b6[7:4]};
    end
  end

  assign sub = v2 ? b8[7:4] : 4'h0;

  rhd_rom_size u_prg_size (
    .msb_nib_i (b9[3:0]),
    .lsb_i     (b4),
    .v2_i      (v2),
    .prg_sel_i (1'b1),
    .size_o    (prg_size),
    .class_o   (prg_class)
  );

  rhd_rom_size u_chr_size (
    .msb_nib_i (b9[7:4]),
    .lsb_i     (b5),
    .v2_i      (v2),
    .prg_sel_i (1'b0),
    .size_o    (chr_size),
    .class_o   (chr_class)
  );

  assign chr_ram = chr_size == 32'h0;

  // Assemble the result; a bad signature leaves everything zero.
  always_comb begin
    result_o = '0;
    if (magic_ok) begin
      result_o.header_ok        = 1'b1;
      result_o.is_version_two   = v2;
      result_o.mapper_number    = mapper;
      result_o.submapper_number = sub;
      result_o.prg_size_bytes   = prg_size;
      result_o.chr_size_bytes   = chr_size;
      if (v2) begin
        result_o.work_ram_bytes  = (b10[3:0] == 4'h0) ? 22'h0 : (RamBaseBytes << b10[3:0]);
        result_o.saved_ram_bytes = (b10[7:4] == 4'h0) ? 22'h0 : (RamBaseBytes << b10[7:4]);
        result_o.tv_region       = b12[1:0];
      end else begin
        result_o.work_ram_bytes  = OldWorkRamBytes;
        result_o.saved_ram_bytes = 22'h0;
        result_o.tv_region       = {1'b0, b9[0]};
      end
      result_o.cart_bits              = {chr_ram, b6[3:0]};
      result_o.fabric_flags[7:0]      = mapper[7:0];
      result_o.fabric_flags[10:8]     = prg_class;
      result_o.fabric_flags[13:11]    = chr_class;
      result_o.fabric_flags[14]       = b6[0];
      result_o.fabric_flags[15]       = chr_ram;
      result_o.fabric_flags[16]       = b6[3];
      result_o.fabric_flags[20:17]    = mapper[11:8];
      result_o.fabric_flags[24:21]    = sub;
      result_o.fabric_flags[25]       = b6[1];
      result_o.fabric_flags[35]       = v2;
      result_o.fabric_flags[37:36]    = result_o.tv_region;
    end
  end

endmodule

// ----- hdl/rom_header_decoder_top.sv -----
// An accepted header is held in the input register; the decode sits between the input and result registers,
// and the result register loads when its stage can advance. Throughput: one header per cycle while ready is high.
// A stalled result blocks a full input stage, but an empty stage always loads.
// Reset (asynchronous, active low) clears the two stage valid flags only.
// Top level of the cartridge header decoder.
module rom_header_decoder_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  rhd_in_if.sink      hdr_i,
  rhd_out_if.source   res_o
);
  import rhd_pkg::*;

  logic        s1_valid_q;
  logic [63:0] hdr_low_q;
  logic [63:0] hdr_high_q;
  logic        out_valid_q;
  rhd_result_t res_q;
  rhd_result_t res_d;
  logic        out_adv;
  logic        s1_adv;

  // Stage advance: a stage loads when it is empty or its contents move on.
  assign out_adv     = !out_valid_q || res_o.ready;
  assign s1_adv      = !s1_valid_q || out_adv;
  assign hdr_i.ready = s1_adv;

  // Valid flags of the two stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_adv) begin
        s1_valid_q <= hdr_i.valid;
      end
      if (out_adv) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (s1_adv && hdr_i.valid) begin
      hdr_low_q  <= hdr_i.header_low;
      hdr_high_q <= hdr_i.header_high;
    end
    if (out_adv && s1_valid_q) begin
      res_q <= res_d;
    end
  end

  rhd_decode u_decode (
    .header_low_i  (hdr_low_q),
    .header_high_i (hdr_high_q),
    .result_o      (res_d)
  );

  // Result channel.
  assign res_o.valid            = out_valid_q;
  assign res_o.header_ok        = res_q.header_ok;
  assign res_o.is_version_two   = res_q.is_version_two;
  assign res_o.mapper_number    = res_q.mapper_number;
  assign res_o.submapper_number = res_q.submapper_number;
  assign res_o.prg_size_bytes   = res_q.prg_size_bytes;
  assign res_o.chr_size_bytes   = res_q.chr_size_bytes;
  assign res_o.work_ram_bytes   = res_q.work_ram_bytes;
  assign res_o.saved_ram_bytes  = res_q.saved_ram_bytes;
  assign res_o.tv_region        = res_q.tv_region;
  assign res_o.cart_bits        = res_q.cart_bits;
  assign res_o.fabric_flags     = res_q.fabric_flags;

  // An accepted transaction always lands in the first stage.
  a_accept_fills_s1 : assert property (@(posedge clk_i) disable iff (!rst_ni)
    hdr_i.valid && hdr_i.ready |=> s1_valid_q)
    else $error("accepted header did not reach the input stage");

  // A bad signature zeroes the flags word, mapper number, work RAM size and cart bits.
  a_bad_magic_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && !res_o.header_ok |-> res_o.fabric_flags == 64'h0 &&
      res_o.mapper_number == 12'h0 && res_o.work_ram_bytes == 22'h0 &&
      res_o.cart_bits == 5'h0)
    else $error("bad signature result carries nonzero fields");

  // The packed flags word agrees with the separate fields.
  a_flags_consistent : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> res_o.fabric_flags[7:0] == res_o.mapper_number[7:0] &&
      res_o.fabric_flags[35] == res_o.is_version_two &&
      res_o.fabric_flags[15] == res_o.cart_bits[4] &&
      res_o.fabric_flags[37:36] == res_o.tv_region)
    else $error("fabric flags disagree with decoded fields");

  // The character RAM flag marks exactly a zero-size character ROM.
  a_chr_ram_flag : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> res_o.cart_bits[4] ==
      (res_o.header_ok && res_o.chr_size_bytes == 32'h0))
    else $error("character RAM flag does not match character ROM size");

endmodule

// ----- sim/rom_header_decoder_top_test.sv -----
// Self-checking testbench for the cartridge header decoder top level.
`timescale 1ns / 100ps

module rom_header_decoder_top_test;
  import rhd_pkg::*;

  typedef struct packed {
    logic [63:0] high;
    logic [63:0] low;
  } header_words_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  rhd_in_if  hdr_if ();
  rhd_out_if res_if ();

  rom_header_decoder_top DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .hdr_i  (hdr_if),
    .res_o  (res_if)
  );

  header_words_t pending_headers[$];
  rhd_result_t   expected_results[$];
  int unsigned   mismatch_count = 0;
  int unsigned   send_wait;
  int unsigned   recv_wait;
  logic          send_burst;
  logic          recv_burst;

  // Free-running clock with a 4 ns period.
  always #2 clk_i = ~clk_i;

  // Exponent-multiplier size form, saturated to 32 bits.
  function automatic logic [31:0] exponent_size(input logic [7:0] code);
    logic [63:0] scaled;
    if (code[7:2] >= 6'd32) return 32'hFFFF_FFFF;
    scaled = (64'd1 << code[7:2]) * (64'd2 * code[1:0] + 64'd1);
    return (scaled > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : scaled[31:0];
  endfunction

  // RAM size from a shift nibble; a zero nibble means no RAM.
  function automatic logic [21:0] ram_bytes(input logic [3:0] shift_nibble);
    return (shift_nibble == 4'h0) ? 22'd0 : (RamBaseBytes << shift_nibble);
  endfunction

  // Smallest power-of-two class that covers the size in units, clamped.
  function automatic logic [2:0] size_class(input logic [31:0] bytes, input int unsigned unit_shift);
    int unsigned units;
    logic [2:0]  cls;
    if (bytes == 32'd0) units = 1;
    else units = (bytes >> unit_shift) + (((bytes & ((32'd1 << unit_shift) - 32'd1)) != 0) ? 1 : 0);
    cls = 3'd0;
    while (cls < MaxSizeClass && (32'd1 << cls) < units) cls++;
    return cls;
  endfunction

  // Full decode of one header into the expected result fields.
  function automatic rhd_result_t decode_header(input logic [63:0] low, input logic [63:0] high);
    logic [7:0]  hb [16];
    rhd_result_t r;
    logic        v2;
    logic [3:0]  prg_msb;
    logic [3:0]  chr_msb;
    r = '0;
    for (int i = 0; i < 8; i++) begin
      hb[i]     = low[8*i +: 8];
      hb[i + 8] = high[8*i +: 8];
    end
    if (hb[0] != MagicB0 || hb[1] != MagicB1 || hb[2] != MagicB2 || hb[3] != MagicB3) begin
      return r;
    end
    v2 = (hb[7][3:2] == Nes2IdCode);
    r.header_ok      = 1'b1;
    r.is_version_two = v2;
    r.mapper_number  = {4'h0, hb[7][7:4], hb[6][7:4]};
    if (v2) begin
      prg_msb = hb[9][3:0];
      chr_msb = hb[9][7:4];
      r.mapper_number[11:8] = hb[8][3:0];
      r.submapper_number    = hb[8][7:4];
      r.prg_size_bytes = (prg_msb == ExpFormNibble) ? exponent_size(hb[4])
                                                    : 32'({prg_msb, hb[4], 14'd0});
      r.chr_size_bytes = (chr_msb == ExpFormNibble) ? exponent_size(hb[5])
                                                    : 32'({chr_msb, hb[5], 13'd0});
      r.work_ram_bytes  = ram_bytes(hb[10][3:0]);
      r.saved_ram_bytes = ram_bytes(hb[10][7:4]);
      r.tv_region       = hb[12][1:0];
    end else begin
      // A dirty old header keeps only the low mapper nibble.
      if (high[63:8] != 56'd0) r.mapper_number[7:4] = 4'h0;
      r.prg_size_bytes  = 32'({hb[4], 14'd0});
      r.chr_size_bytes  = 32'({hb[5], 13'd0});
      r.work_ram_bytes  = OldWorkRamBytes;
      r.saved_ram_bytes = 22'd0;
      r.tv_region       = {1'b0, hb[9][0]};
    end
    r.cart_bits = {(r.chr_size_bytes == 32'd0), hb[6][3:0]};
    r.fabric_flags[7:0]   = r.mapper_number[7:0];
    r.fabric_flags[10:8]  = size_class(r.prg_size_bytes, 14);
    r.fabric_flags[13:11] = size_class(r.chr_size_bytes, 13);
    r.fabric_flags[14]    = hb[6][0];
    r.fabric_flags[15]    = r.cart_bits[4];
    r.fabric_flags[16]    = hb[6][3];
    r.fabric_flags[20:17] = r.mapper_number[11:8];
    r.fabric_flags[24:21] = r.submapper_number;
    r.fabric_flags[25]    = hb[6][1];
    r.fabric_flags[35]    = v2;
    r.fabric_flags[37:36] = r.tv_region;
    return r;
  endfunction

  // Header with a valid signature, bytes 4..7 given singly and bytes 8..15 as one word.
  function automatic header_words_t with_magic(input logic [7:0] prg_lsb, input logic [7:0] chr_lsb,
                                               input logic [7:0] flags6, input logic [7:0] flags7,
                                               input logic [63:0] high);
    header_words_t h;
    h.low  = {flags7, flags6, chr_lsb, prg_lsb, MagicB3, MagicB2, MagicB1, MagicB0};
    h.high = high;
    return h;
  endfunction

  // Random header: mostly well-formed version two and old headers, some noise.
  function automatic header_words_t random_header();
    header_words_t h;
    int unsigned   kind;
    int unsigned   bit_pos;
    kind   = $urandom_range(0, 99);
    h.low  = {$urandom, $urandom};
    h.high = {$urandom, $urandom};
    if (kind < 10) return h;
    h.low[31:0] = {MagicB3, MagicB2, MagicB1, MagicB0};
    if (kind < 16) begin
      // Signature off by a single bit.
      bit_pos = $urandom_range(0, 31);
      h.low[bit_pos] = ~h.low[bit_pos];
      return h;
    end
    if (kind < 58) begin
      h.low[59:58] = Nes2IdCode;
      if ($urandom_range(0, 2) == 0) h.high[11:8] = ExpFormNibble;
      if ($urandom_range(0, 2) == 0) h.high[15:12] = ExpFormNibble;
      if ($urandom_range(0, 5) == 0) begin
        h.low[47:40]  = 8'h00;
        h.high[15:12] = 4'h0;
      end
      if ($urandom_range(0, 5) == 0) h.high[15:8] = 8'h00;
    end else begin
      case ($urandom_range(0, 2))
        0: h.low[59:58] = 2'b00;
        1: h.low[59:58] = 2'b01;
        default: h.low[59:58] = 2'b11;
      endcase
      if ($urandom_range(0, 1) == 0) h.high[63:8] = 56'd0;
      if ($urandom_range(0, 7) == 0) h.low[47:40] = 8'h00;
    end
    return h;
  endfunction

  // Compares one result field and reports a mismatch.
  task automatic check_field(input string field, input logic [63:0] want, input logic [63:0] got);
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= 50) begin
        $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
      end
    end
  endtask

  // Header driver: presents queued headers with random gaps between transactions.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_if.valid       <= 1'b0;
      hdr_if.header_low  <= '0;
      hdr_if.header_high <= '0;
      send_wait          <= 0;
      send_burst         <= 1'b0;
    end else begin
      if (hdr_if.valid && hdr_if.ready) begin
        expected_results.push_back(decode_header(hdr_if.header_low, hdr_if.header_high));
      end
      if (!hdr_if.valid || hdr_if.ready) begin
        if (send_wait != 0 || pending_headers.size() == 0) begin
          hdr_if.valid <= 1'b0;
          if (send_wait != 0) send_wait <= send_wait - 1;
        end else begin
          hdr_if.valid       <= 1'b1;
          hdr_if.header_low  <= pending_headers[0].low;
          hdr_if.header_high <= pending_headers[0].high;
          void'(pending_headers.pop_front());
          send_wait <= send_burst ? 0 : $urandom_range(0, 5);
          if ($urandom_range(0, 39) == 0) send_burst <= ~send_burst;
        end
      end
    end
  end

  // Result monitor: checks each result transaction and stalls ready at random.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      recv_wait    = 0;
      recv_burst   <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (expected_results.size() == 0) begin
          mismatch_count++;
          $display("%0t ns: result with no header pending, actual fabric_flags 0x%0h",
                   $time, res_if.fabric_flags);
        end else begin
          check_field("header_ok", 64'(expected_results[0].header_ok), 64'(res_if.header_ok));
          check_field("is_version_two", 64'(expected_results[0].is_version_two),
                      64'(res_if.is_version_two));
          check_field("mapper_number", 64'(expected_results[0].mapper_number),
                      64'(res_if.mapper_number));
          check_field("submapper_number", 64'(expected_results[0].submapper_number),
                      64'(res_if.submapper_number));
          check_field("prg_size_bytes", 64'(expected_results[0].prg_size_bytes),
                      64'(res_if.prg_size_bytes));
          check_field("chr_size_bytes", 64'(expected_results[0].chr_size_bytes),
                      64'(res_if.chr_size_bytes));
          check_field("work_ram_bytes", 64'(expected_results[0].work_ram_bytes),
                      64'(res_if.work_ram_bytes));
          check_field("saved_ram_bytes", 64'(expected_results[0].saved_ram_bytes),
                      64'(res_if.saved_ram_bytes));
          check_field("tv_region", 64'(expected_results[0].tv_region), 64'(res_if.tv_region));
          check_field("cart_bits", 64'(expected_results[0].cart_bits), 64'(res_if.cart_bits));
          check_field("fabric_flags", expected_results[0].fabric_flags, res_if.fabric_flags);
          void'(expected_results.pop_front());
        end
        if (recv_burst) begin
          res_if.ready <= 1'b1;
        end else begin
          recv_wait = $urandom_range(0, 5);
          res_if.ready <= (recv_wait == 0);
          if (recv_wait != 0) recv_wait = recv_wait - 1;
        end
        if ($urandom_range(0, 39) == 0) recv_burst <= ~recv_burst;
      end else if (!res_if.ready) begin
        if (recv_wait == 0) res_if.ready <= 1'b1;
        else recv_wait = recv_wait - 1;
      end
    end
  end

  // Stimulus: directed headers, then random ones; waits for all results.
  initial begin
    hdr_if.valid       = 1'b0;
    hdr_if.header_low  = '0;
    hdr_if.header_high = '0;
    res_if.ready       = 1'b0;
    rst_ni             = 1'b0;

    // Bad signatures.
    pending_headers.push_back('{high: 64'h0, low: 64'h0});
    pending_headers.push_back('{high: '1, low: '1});
    pending_headers.push_back('{high: 64'h0, low: {32'h0000_0101, 8'h1B, MagicB2, MagicB1, MagicB0}});
    pending_headers.push_back('{high: 64'h0, low: {32'h0, MagicB3, MagicB2, MagicB1, 8'h4F}});
    // Old format: clean, extremes, empty sizes, dirty, and odd version bits.
    pending_headers.push_back(with_magic(8'h02, 8'h01, 8'h41, 8'h00, 64'h0));
    pending_headers.push_back(with_magic(8'hFF, 8'hFF, 8'hFF, 8'hF0, 64'h0));
    pending_headers.push_back(with_magic(8'h00, 8'h00, 8'h10, 8'h00, 64'h0));
    pending_headers.push_back(with_magic(8'h08, 8'h00, 8'hA0, 8'h50, 64'hFF00_0000_0000_0000));
    pending_headers.push_back(with_magic(8'h04, 8'h02, 8'h33, 8'h70, 64'h0000_0000_0000_0100));
    pending_headers.push_back(with_magic(8'h01, 8'h01, 8'h25, 8'hC0, 64'h0000_0000_0000_00FF));
    pending_headers.push_back(with_magic(8'h01, 8'h01, 8'h10, 8'h24, 64'h0000_0000_0000_0F00));
    pending_headers.push_back(with_magic(8'h10, 8'h08, 8'h96, 8'h3C, 64'h0));
    // Version two: minimum, extremes, exponent form, saturation and RAM nibbles.
    pending_headers.push_back(with_magic(8'h01, 8'h00, 8'h00, 8'h08, 64'h0));
    pending_headers.push_back(with_magic(8'hFF, 8'hFF, 8'hFF, 8'hF8, 64'h0000_0000_0000_EEFF));
    pending_headers.push_back(with_magic(8'h00, 8'h03, 8'h02, 8'h08, 64'h0000_0000_0000_FF00));
    pending_headers.push_back(with_magic(8'h7F, 8'h80, 8'h01, 8'h08, 64'h0000_0000_0000_FF00));
    pending_headers.push_back(with_magic(8'h7C, 8'hFC, 8'h04, 8'h0B, 64'h0000_0000_0000_FF00));
    pending_headers.push_back(with_magic(8'h39, 8'h35, 8'h08, 8'h09, 64'h0000_0000_0000_FF00));
    pending_headers.push_back(with_magic(8'h02, 8'h02, 8'h50, 8'h18, 64'h0000_0000_00F1_0000));
    pending_headers.push_back(with_magic(8'h02, 8'h00, 8'h60, 8'h28, 64'h0000_00FD_001F_0000));
    pending_headers.push_back(with_magic(8'h00, 8'h00, 8'h00, 8'h08, 64'h0000_0003_0000_0000));
    pending_headers.push_back(with_magic(8'h20, 8'h40, 8'h0F, 8'h48, 64'hA5A5_0002_5A00_0000));
    repeat (750) pending_headers.push_back(random_header());

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_headers.size() != 0 || hdr_if.valid || expected_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (10) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("[rom_header_decoder_top] OK");
    end else begin
      $display("[rom_header_decoder_top] ERROR");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #1000000;
    $display("[rom_header_decoder_top] ERROR");
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/rhd_pkg.sv
hdl/rhd_in_if.sv
hdl/rhd_out_if.sv
hdl/rhd_rom_size.sv
hdl/rhd_decode.sv
hdl/rom_header_decoder_top.sv
sim/rom_header_decoder_top_test.sv
